// ----- rtl/dfu_image_receiver_crc32_core_macros.svh -----
// Assertion helpers for the DFU receiver core.
`ifndef DFU_IMAGE_RECEIVER_CRC32_CORE_MACROS_SVH
`define DFU_IMAGE_RECEIVER_CRC32_CORE_MACROS_SVH

`ifndef SYNTH
`define DFU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dfu core check failed");
`define DFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dfu core implication failed");
`else
`define DFU_ASSERT(lbl, prop)
`define DFU_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ----- rtl/dfu_crc_pkg.sv -----
package dfu_crc_pkg;

  localparam int MAX_PACKET_BYTES = 512;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL      = 32'hFFFFFFFF;
  localparam logic [15:0] PRN_MIN      = 16'd8;
  localparam logic [15:0] PRN_MAX      = 16'd128;
  localparam logic [7:0]  DATA_OBJECT  = 8'd2;
  localparam logic [24:0] CAPACITY_CAP = 25'd16777216;
  localparam logic [24:0] MAX_SIZE_RST = 25'd1966080;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_CREATE = 3'd1;
  localparam logic [2:0] KIND_PRN    = 3'd2;
  localparam logic [2:0] KIND_CRC    = 3'd3;
  localparam logic [2:0] KIND_EXEC   = 3'd4;
  localparam logic [2:0] KIND_SELECT = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FAILED  = 2'd2;

  typedef struct packed {
    logic        response_valid;
    logic [2:0]  response_kind;
    logic [1:0]  status;
    logic [24:0] offset_out;
    logic [31:0] crc_out;
    logic [24:0] max_size_out;
    logic        write_enable;
    logic [23:0] write_address;
    logic [7:0]  write_data;
    logic        apply_image;
  } result_t;

  // Fold one byte into a finalized (post-xor) reflected CRC32.
  function automatic logic [31:0] crc_add_byte(input logic [31:0] fin, input logic [7:0] b);
    logic [31:0] c;
    c = ~fin ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c ^ CRC_ALL;
  endfunction

endpackage

// ----- rtl/dfu_crc_in_if.sv -----
interface dfu_crc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [9:0]  packet_len;
  logic        first_in_packet;
  logic [7:0]  object_type;
  logic [31:0] object_size;
  logic [15:0] prn_request;

  modport source (
    output valid, kind, data_byte, packet_len, first_in_packet, object_type,
           object_size, prn_request,
    input  ready
  );
  modport sink (
    input  valid, kind, data_byte, packet_len, first_in_packet, object_type,
           object_size, prn_request,
    output ready
  );
endinterface

// ----- rtl/dfu_crc_out_if.sv -----
interface dfu_crc_out_if;
  logic        valid;
  logic        ready;
  logic        response_valid;
  logic [2:0]  response_kind;
  logic [1:0]  status;
  logic [24:0] offset_out;
  logic [31:0] crc_out;
  logic [24:0] max_size_out;
  logic        write_enable;
  logic [23:0] write_address;
  logic [7:0]  write_data;
  logic        apply_image;

  modport source (
    output valid, response_valid, response_kind, status, offset_out, crc_out,
           max_size_out, write_enable, write_address, write_data, apply_image,
    input  ready
  );
  modport sink (
    input  valid, response_valid, response_kind, status, offset_out, crc_out,
           max_size_out, write_enable, write_address, write_data, apply_image,
    output ready
  );
endinterface

// ----- rtl/dfu_image_receiver_crc32_core.sv -----
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   command or image byte (kind, data_byte, packet_len, ...)
// out_o    out  valid/ready   one result item per input item
// cfg      in   cfg_we_i      max_image_size (cfg_wdata_i)
//
// One item per cycle: state and result are computed in the accept cycle
// (the bytewise CRC32 step is the longest path) and the result lands in the output
// register. The input stalls only while that register is full and not taken.
// rst_ni clears all session state and restores the default capacity.
`include "dfu_image_receiver_crc32_core_macros.svh"

module dfu_image_receiver_crc32_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [24:0]   cfg_wdata_i,
  dfu_crc_in_if.sink    in_i,
  dfu_crc_out_if.source out_o
);

  logic [24:0] max_size_q;
  logic [24:0] bw_q, bw_d;
  logic [24:0] exp_q, exp_d;
  logic [31:0] crc_q, crc_d;
  logic        sess_q, sess_d;
  logic [7:0]  ni_q, ni_d;
  logic [7:0]  psn_q, psn_d;
  logic [9:0]  pbl_q, pbl_d;
  logic        drop_q, drop_d;

  logic                 out_valid_q;
  dfu_crc_pkg::result_t res_q, res_d;
  logic                 in_fire;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= dfu_crc_pkg::MAX_SIZE_RST;
    end else if (cfg_we_i) begin
      max_size_q <= (cfg_wdata_i > dfu_crc_pkg::CAPACITY_CAP) ?
                    dfu_crc_pkg::CAPACITY_CAP : cfg_wdata_i;
    end
  end

  always_comb begin
    bw_d   = bw_q;
    exp_d  = exp_q;
    crc_d  = crc_q;
    sess_d = sess_q;
    ni_d   = ni_q;
    psn_d  = psn_q;
    pbl_d  = pbl_q;
    drop_d = drop_q;
    res_d  = '0;
    if (in_fire) begin
      unique case (in_i.kind)
        dfu_crc_pkg::KIND_DATA: begin
          if (in_i.first_in_packet) begin
            pbl_d  = '0;
            drop_d = 1'b1;
            if (in_i.packet_len != 10'd0 &&
                in_i.packet_len <= 10'(dfu_crc_pkg::MAX_PACKET_BYTES) && sess_q) begin
              // overrun closes the session
              if ({1'b0, bw_q} + {16'd0, in_i.packet_len} > {1'b0, exp_q}) begin
                sess_d = 1'b0;
              end else begin
                pbl_d  = in_i.packet_len;
                drop_d = 1'b0;
              end
            end
          end
          if (!drop_d && pbl_d != 10'd0) begin
            res_d.write_enable  = 1'b1;
            res_d.write_address = bw_q[23:0];
            res_d.write_data    = in_i.data_byte;
            crc_d = dfu_crc_pkg::crc_add_byte(crc_q, in_i.data_byte);
            bw_d  = bw_q + 25'd1;
            pbl_d = pbl_d - 10'd1;
            if (pbl_d == 10'd0 && ni_q != 8'd0) begin
              psn_d = psn_q + 8'd1;
              if (psn_d >= ni_q) begin
                psn_d                = '0;
                res_d.response_valid = 1'b1;
                res_d.response_kind  = dfu_crc_pkg::KIND_CRC;
                res_d.offset_out     = bw_d;
                res_d.crc_out        = crc_d;
              end
            end
          end
        end
        dfu_crc_pkg::KIND_CREATE: begin
          res_d.response_valid = 1'b1;
          res_d.response_kind  = dfu_crc_pkg::KIND_CREATE;
          if (in_i.object_type != dfu_crc_pkg::DATA_OBJECT || in_i.object_size == 32'd0 ||
              in_i.object_size > {7'd0, max_size_q}) begin
            res_d.status = dfu_crc_pkg::STATUS_INVALID;
          end else begin
            bw_d   = '0;
            exp_d  = in_i.object_size[24:0];
            crc_d  = '0;
            sess_d = 1'b1;
            psn_d  = '0;
            pbl_d  = '0;
            drop_d = 1'b0;
          end
        end
        dfu_crc_pkg::KIND_PRN: begin
          res_d.response_valid = 1'b1;
          res_d.response_kind  = dfu_crc_pkg::KIND_PRN;
          if (in_i.prn_request < dfu_crc_pkg::PRN_MIN ||
              in_i.prn_request > dfu_crc_pkg::PRN_MAX) begin
            res_d.status = dfu_crc_pkg::STATUS_INVALID;
          end else begin
            ni_d = in_i.prn_request[7:0];
          end
        end
        dfu_crc_pkg::KIND_CRC: begin
          res_d.response_valid = 1'b1;
          res_d.response_kind  = dfu_crc_pkg::KIND_CRC;
          res_d.offset_out     = bw_q;
          res_d.crc_out        = crc_q;
        end
        dfu_crc_pkg::KIND_EXEC: begin
          res_d.response_valid = 1'b1;
          res_d.response_kind  = dfu_crc_pkg::KIND_EXEC;
          if (!sess_q || bw_q != exp_q) begin
            res_d.status = dfu_crc_pkg::STATUS_FAILED;
          end else begin
            res_d.apply_image = 1'b1;
            psn_d             = '0;
          end
          sess_d = 1'b0;
        end
        dfu_crc_pkg::KIND_SELECT: begin
          res_d.response_valid = 1'b1;
          res_d.response_kind  = dfu_crc_pkg::KIND_SELECT;
          if (in_i.object_type != dfu_crc_pkg::DATA_OBJECT) begin
            res_d.status = dfu_crc_pkg::STATUS_INVALID;
          end else begin
            res_d.offset_out   = bw_q;
            res_d.max_size_out = max_size_q;
            res_d.crc_out      = (bw_q != 25'd0) ? crc_q : 32'd0;
          end
        end
        default: begin
          // unknown kind: silent empty result
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q        <= '0;
      exp_q       <= '0;
      crc_q       <= '0;
      sess_q      <= 1'b0;
      ni_q        <= '0;
      psn_q       <= '0;
      pbl_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bw_q   <= bw_d;
      exp_q  <= exp_d;
      crc_q  <= crc_d;
      sess_q <= sess_d;
      ni_q   <= ni_d;
      psn_q  <= psn_d;
      pbl_q  <= pbl_d;
      drop_q <= drop_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.response_valid = res_q.response_valid;
  assign out_o.response_kind  = res_q.response_kind;
  assign out_o.status         = res_q.status;
  assign out_o.offset_out     = res_q.offset_out;
  assign out_o.crc_out        = res_q.crc_out;
  assign out_o.max_size_out   = res_q.max_size_out;
  assign out_o.write_enable   = res_q.write_enable;
  assign out_o.write_address  = res_q.write_address;
  assign out_o.write_data     = res_q.write_data;
  assign out_o.apply_image    = res_q.apply_image;

  `DFU_ASSERT(a_write_advances, (in_fire && res_d.write_enable) |=> (bw_q == 25'($past(bw_q) + 25'd1)))
  `DFU_ASSERT(a_apply_closes, (in_fire && res_d.apply_image) |=> !sess_q)
  `DFU_ASSERT_IMPL(a_within_size, sess_q, bw_q <= exp_q)
  `DFU_ASSERT_IMPL(a_notify_reset, in_fire && in_i.kind == dfu_crc_pkg::KIND_DATA && res_d.response_valid, psn_d == 8'd0)

endmodule
